[rtl/stbs_pkg.sv]
// Shared types and constants for the sorted-table binary search block.
// Used by stbs_front, stbs_back and sorted_table_binary_search.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 256;
  localparam int INDEX_W = 8;
  localparam int VALUE_W = 32;
  localparam int SIZE_W = 9;

  localparam logic ACT_SEARCH = 1'b1;

  // One classified word as it waits between the front and the back.
  typedef struct packed {
    logic                      is_search;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] operand;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef struct packed {
    logic searching;
    logic writing;
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_PROBE
  } state_t;

endpackage

[rtl/stbs_front.sv]
// Input side: accepts words, classifies them as load or search, and holds them
// in a two-word queue for the back end. Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               action,
  input  logic [stbs_pkg::INDEX_W-1:0]       entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] entry_value,
  input  logic signed [stbs_pkg::VALUE_W-1:0] search_key,
  output stbs_pkg::qhead_t                   head,
  input  logic                               head_take
);

  stbs_pkg::cmd_t q [2];
  stbs_pkg::cmd_t cmd_in;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push_ok;
  logic           pop_ok;

  always_comb begin
    cmd_in.is_search = (action == stbs_pkg::ACT_SEARCH);
    cmd_in.index     = entry_index;
    cmd_in.operand   = cmd_in.is_search ? search_key : entry_value;
  end

  assign full       = (count == 2'd2);
  assign push_ok    = push && !full;
  assign pop_ok     = head_take && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/stbs_back.sv]
// Execution side: table memory, the probe sequencer and the result slot.
// Depends on stbs_pkg; fed by stbs_front.
`timescale 1ns / 1ps

module stbs_back #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  stbs_pkg::qhead_t              head,
  output logic                          head_take,
  input  logic [stbs_pkg::SIZE_W-1:0]   table_size,
  output stbs_pkg::status_t             status,
  input  logic                          res_pop,
  output logic                          res_empty,
  output logic                          hit,
  output logic [stbs_pkg::INDEX_W-1:0]  position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int BW = $clog2(TABLE_DEPTH + 1) + 1;

  logic signed [stbs_pkg::VALUE_W-1:0] entries [TABLE_DEPTH];
  logic signed [stbs_pkg::VALUE_W-1:0] rd_data;
  logic signed [stbs_pkg::VALUE_W-1:0] key;

  stbs_pkg::state_t state, state_next;

  logic signed [BW-1:0] lo;
  logic signed [BW-1:0] hi;
  logic [AW-1:0]        mid;
  logic signed [BW-1:0] n_eff;
  logic signed [BW-1:0] cand_lo;
  logic signed [BW-1:0] cand_hi;
  logic [BW:0]          sum;
  logic [AW-1:0]        mid_next;
  logic                 crossed;
  logic                 in_range;
  logic                 mem_we;
  logic                 rd_en;
  logic                 key_load;
  logic                 finish;
  logic                 fin_hit;
  logic                 res_valid;

  assign n_eff = (32'(table_size) > TABLE_DEPTH) ? BW'(TABLE_DEPTH) : BW'(table_size);
  assign in_range = (32'(head.cmd.index) < TABLE_DEPTH);

  // Candidate bounds: the initial range when a search starts, otherwise the
  // range narrowed by the entry that came back from the last probe.
  always_comb begin
    cand_lo = '0;
    cand_hi = n_eff - BW'(1);
    if (state == stbs_pkg::ST_PROBE) begin
      if (rd_data > key) begin
        cand_lo = lo;
        cand_hi = $signed(BW'(mid)) - BW'(1);
      end else begin
        cand_lo = $signed(BW'(mid)) + BW'(1);
        cand_hi = hi;
      end
    end
  end

  assign crossed  = (cand_lo > cand_hi);
  assign sum      = (BW + 1)'(cand_lo) + (BW + 1)'(cand_hi);
  assign mid_next = sum[AW:1];

  always_comb begin
    state_next = state;
    head_take  = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    key_load   = 1'b0;
    finish     = 1'b0;
    fin_hit    = 1'b0;
    unique case (state)
      stbs_pkg::ST_IDLE: begin
        if (head.valid) begin
          if (!head.cmd.is_search) begin
            head_take = 1'b1;
            mem_we    = in_range;
          end else if (!res_valid) begin
            // A search starts only with the result slot free, so it can
            // always finish without waiting.
            head_take = 1'b1;
            key_load  = 1'b1;
            if (crossed) begin
              finish = 1'b1;
            end else begin
              rd_en      = 1'b1;
              state_next = stbs_pkg::ST_PROBE;
            end
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (rd_data == key) begin
          finish     = 1'b1;
          fin_hit    = 1'b1;
          state_next = stbs_pkg::ST_IDLE;
        end else if (crossed) begin
          finish     = 1'b1;
          state_next = stbs_pkg::ST_IDLE;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: state_next = stbs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries[AW'(head.cmd.index)] <= head.cmd.operand;
    end
    if (rd_en) begin
      rd_data <= entries[mid_next];
    end
  end

  always_ff @(posedge clk) begin
    if (key_load) begin
      key <= head.cmd.operand;
    end
    if (rd_en) begin
      lo  <= cand_lo;
      hi  <= cand_hi;
      mid <= mid_next;
    end
    if (finish) begin
      hit      <= fin_hit;
      position <= fin_hit ? stbs_pkg::INDEX_W'(mid) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stbs_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign res_empty        = !res_valid;
  assign status.searching = (state == stbs_pkg::ST_PROBE);
  assign status.writing   = mem_we;

endmodule

[rtl/sorted_table_binary_search.sv]
// Sorted-table binary search, top level: config register and the two halves.
// Depends on stbs_pkg, stbs_front and stbs_back.
`timescale 1ns / 1ps

// Usage:
// Words enter through push/full and are taken when push is high and full is
// low. A load word (action 0) writes entry_value at entry_index and gives no
// result; a search word (action 1) gives one result word with hit and
// position, shown while empty is low and taken when pop is high.
// A two-word queue sits between the input and the search engine, so up to
// two words can be accepted while a search runs, though none is taken until it ends.
// Timing: a load at the queue head is written while no search runs, one load
// per cycle. A search probes one entry per cycle through the registered
// memory read; for an empty table it finishes without a probe, otherwise
// after at most floor(log2(table_size)) + 1 probes.
// A new search starts only once the previous result has been popped,
// so a stalled receiver halts searches while loads queued ahead continue.
// cfg_we/cfg_wdata set table_size; write it only while the block is idle.
// Reset clears table_size, the queue and the result slot; table contents are
// kept and must be loaded before they are searched.

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                action,
  input  logic [stbs_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] entry_value,
  input  logic signed [stbs_pkg::VALUE_W-1:0] search_key,
  output logic                                empty,
  input  logic                                pop,
  output logic                                hit,
  output logic [stbs_pkg::INDEX_W-1:0]        position,
  input  logic                                cfg_we,
  input  logic [stbs_pkg::SIZE_W-1:0]         cfg_wdata
);

  logic [stbs_pkg::SIZE_W-1:0] table_size;
  stbs_pkg::qhead_t            head;
  stbs_pkg::status_t           status;
  logic                        head_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= '0;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  stbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .head        (head),
    .head_take   (head_take)
  );

  stbs_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_take  (head_take),
    .table_size (table_size),
    .status     (status),
    .res_pop    (pop),
    .res_empty  (empty),
    .hit        (hit),
    .position   (position)
  );

`ifndef ASSERT_OFF
  // A running search always has a free result slot to finish into.
  a_search_slot_free: assert property (@(posedge clk) disable iff (rst)
    status.searching |-> empty)
    else $error("search running while result slot occupied");

  // The table is written only from a load word at the queue head.
  a_write_from_head: assert property (@(posedge clk) disable iff (rst)
    status.writing |-> (head.valid && !head.cmd.is_search && head_take))
    else $error("table write without a load word");

  // A full queue always presents a word to the back end.
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    full |-> head.valid)
    else $error("queue full but head not valid");

  // A result appears only from a search that was running or just taken.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> ($past(status.searching) ||
                      ($past(head_take) && $past(head.cmd.is_search))))
    else $error("result word without a search");
`endif

endmodule
